/* hdl/medq_pkg.sv */
// ----------------------------------------------------------------------------
// medq_pkg
// Shared types and constants for the MIDI event delay queue.
// ----------------------------------------------------------------------------
package medq_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int SLOT_W = $clog2(EVENT_SLOTS);
  localparam int CNT_W = $clog2(EVENT_SLOTS + 1);
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        is_midi;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic signed [31:0] delay_frames;
    logic [15:0] sample_pos;
    logic [15:0] block_frames;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [6:0] out_data_one;
    logic [6:0] out_data_two;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

  localparam logic [3:0] T_OFF = 4'h8;
  localparam logic [3:0] T_ON  = 4'h9;
  localparam logic [3:0] T_PAT = 4'hA;
  localparam logic [3:0] T_CC  = 4'hB;
  localparam logic [3:0] T_PC  = 4'hC;
  localparam logic [3:0] T_CAT = 4'hD;
  localparam logic [3:0] T_PB  = 4'hE;

  // returns valid flag in bit 23 with message in low bits
  function automatic logic [23:0] rebuild(input logic [7:0] st, input logic [7:0] d1,
                                          input logic [7:0] d2);
    logic [3:0] ty;
    logic [6:0] o2;
    logic       ok;
    ty = st[7:4];
    o2 = d2[6:0];
    ok = 1'b1;
    case (ty)
      T_ON: if (o2 == 7'd0) ty = T_OFF;
      T_OFF, T_PAT, T_CC, T_PB: ok = 1'b1;
      T_PC, T_CAT: o2 = 7'd0;
      default: ok = 1'b0;
    endcase
    return {ok, ty, st[3:0], d1[6:0], o2, 1'b0};
  endfunction

endpackage

/* hdl/medq_front.sv */
// ----------------------------------------------------------------------------
// medq_front
// Input stage: drops non-MIDI inserts and unknown opcodes, queues the rest.
// ----------------------------------------------------------------------------
module medq_front import medq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     push,
  output logic     full,
  output in_item_t cmd,
  output logic     cmd_valid,
  input  logic     cmd_take
);

  in_item_t q [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic keep, acc;

  assign full = (cnt == 2'd2);
  assign acc = push && !full;
  assign keep = (in_item.opcode == OP_TICK) || (in_item.opcode == OP_END) ||
                ((in_item.opcode == OP_INSERT) && in_item.is_midi);
  assign cmd = q[rp];
  assign cmd_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (acc && keep) begin
        q[wp] <= in_item;
        wp <= ~wp;
      end
      if (cmd_take && cmd_valid) rp <= ~rp;
      cnt <= cnt + {1'b0, acc && keep} - {1'b0, cmd_take && cmd_valid};
    end
  end

endmodule

/* hdl/medq_div.sv */
// ----------------------------------------------------------------------------
// medq_div
// Radix-2 restoring remainder unit, truncating sign, one bit per cycle.
// ----------------------------------------------------------------------------
module medq_div import medq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic        neg,
  output logic [15:0] rem
);

  logic [31:0] mag;
  logic [16:0] r;
  logic [5:0]  n;
  logic        busy;
  logic [16:0] sh, sub;

  assign sh  = {r[15:0], mag[31]};
  assign sub = sh - {1'b0, divisor};
  assign rem = r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mag <= dividend[31] ? (32'd0 - dividend) : dividend;
        neg <= dividend[31];
        r <= 17'd0;
        n <= 6'(DIV_STEPS);
      end else if (busy) begin
        mag <= {mag[30:0], 1'b0};
        r <= sub[16] ? sh : sub;
        n <= n - 6'd1;
        if (n == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/medq_back.sv */
// ----------------------------------------------------------------------------
// medq_back
// Slot store and sequencer: insert, tick walk with remainder, end-of-block.
// ----------------------------------------------------------------------------
module medq_back import medq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  cmd,
  input  logic      cmd_valid,
  output logic      cmd_take,
  output out_item_t res,
  output logic      empty,
  input  logic      pop
);

  logic [EVENT_SLOTS-1:0] valid;
  logic [31:0] dly [EVENT_SLOTS];
  logic [7:0]  sst [EVENT_SLOTS];
  logic [7:0]  sd1 [EVENT_SLOTS];
  logic [7:0]  sd2 [EVENT_SLOTS];
  logic [SLOT_W-1:0] order [EVENT_SLOTS];
  logic [CNT_W-1:0] count, idx, kept;

  state_t state, state_next;
  logic [SLOT_W-1:0] cur, free_slot;
  logic free_ok;
  logic div_start, div_done, div_neg;
  logic [15:0] div_rem;
  logic hit;
  logic [23:0] msg;

  // one-deep hold of a message, emitted when the next one or the end is known
  out_item_t hold;
  logic      hold_v;
  out_item_t oq [2];
  logic [1:0] ocnt;
  logic owp, orp;
  logic push_o, pop_o;
  out_item_t push_d;

  assign cur = order[idx[SLOT_W-1:0]];

  always_comb begin
    free_ok = 1'b0;
    free_slot = '0;
    for (int k = EVENT_SLOTS - 1; k >= 1; k--) begin
      if (!valid[k]) begin
        free_ok = 1'b1;
        free_slot = SLOT_W'(k);
      end
    end
  end

  medq_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dly[cur]),
    .divisor(cmd.block_frames), .done(div_done), .neg(div_neg), .rem(div_rem)
  );

  // a negative delay with zero remainder still matches position zero
  assign hit = (!div_neg || div_rem == 16'd0) && (div_rem == cmd.sample_pos) && valid[cur];
  assign msg = rebuild(sst[cur], sd1[cur], sd2[cur]);

  assign empty = (ocnt == 2'd0);
  assign res = oq[orp];
  assign pop_o = pop && !empty;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (cmd_valid) begin
          case (op_t'(cmd.opcode))
            OP_TICK: state_next = (cmd.block_frames == 16'd0 || count == '0) ?
                                  ST_IDLE : ST_FETCH;
            OP_END:  state_next = (count == '0) ? ST_IDLE : ST_FETCH;
            default: state_next = ST_IDLE;
          endcase
        end
      ST_FETCH:
        if (op_t'(cmd.opcode) == OP_END) state_next = (idx + 1'b1 == count) ? ST_IDLE : ST_FETCH;
        else state_next = ST_DIV;
      ST_DIV:
        if (div_done) state_next = ST_DECIDE;
      ST_DECIDE:
        if (!(hit && msg[23] && hold_v && ocnt == 2'd2))
          state_next = (idx + 1'b1 == count) ? ST_FLUSH : ST_FETCH;
      ST_FLUSH:
        if (!hold_v || ocnt != 2'd2) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = 1'b0;
    div_start = 1'b0;
    push_o = 1'b0;
    push_d = hold;
    case (state)
      ST_IDLE:
        if (cmd_valid && state_next == ST_IDLE) cmd_take = 1'b1;
      ST_FETCH: begin
        div_start = (op_t'(cmd.opcode) == OP_TICK);
        cmd_take = (op_t'(cmd.opcode) == OP_END) && (idx + 1'b1 == count);
      end
      ST_DECIDE:
        push_o = hit && msg[23] && hold_v && ocnt != 2'd2;
      ST_FLUSH:
        if (!hold_v || ocnt != 2'd2) begin
          push_o = hold_v;
          push_d.last = 1'b1;
          cmd_take = 1'b1;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      count <= '0;
      hold_v <= 1'b0;
      ocnt <= 2'd0;
      owp <= 1'b0;
      orp <= 1'b0;
    end else begin
      state <= state_next;
      if (push_o) begin
        oq[owp] <= push_d;
        owp <= ~owp;
      end
      if (pop_o) orp <= ~orp;
      ocnt <= ocnt + {1'b0, push_o} - {1'b0, pop_o};
      case (state)
        ST_IDLE: begin
          idx <= '0;
          kept <= '0;
          hold_v <= 1'b0;
          if (cmd_valid && op_t'(cmd.opcode) == OP_INSERT &&
              count < CNT_W'(EVENT_SLOTS - 1) && free_ok) begin
            valid[free_slot] <= 1'b1;
            dly[free_slot] <= cmd.delay_frames;
            sst[free_slot] <= cmd.status_byte;
            sd1[free_slot] <= cmd.data_one;
            sd2[free_slot] <= cmd.data_two;
            order[count[SLOT_W-1:0]] <= free_slot;
            count <= count + 1'b1;
          end
        end
        ST_FETCH:
          if (op_t'(cmd.opcode) == OP_END) begin
            dly[cur] <= dly[cur] - {16'd0, cmd.block_frames};
            idx <= idx + 1'b1;
          end
        ST_DECIDE:
          if (state_next != ST_DECIDE) begin
            idx <= idx + 1'b1;
            if (hit) begin
              valid[cur] <= 1'b0;
              if (msg[23]) begin
                hold <= msg[22:0];
                hold_v <= 1'b1;
              end
            end else begin
              order[kept[SLOT_W-1:0]] <= cur;
              kept <= kept + 1'b1;
            end
          end
        ST_FLUSH:
          if (state_next == ST_IDLE) begin
            count <= kept;
            hold_v <= 1'b0;
          end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/midi_event_delay_queue_core.sv */
// ----------------------------------------------------------------------------
// midi_event_delay_queue_core
// Sample-accurate MIDI event delay queue with 15 usable slots.
// ----------------------------------------------------------------------------
// Inserts and non-matching items are handled without walking the list. A tick walks the
// pending list in arrival order; each entry runs a 32-step serial remainder. End of
// block subtracts the block length from each pending delay. Released messages leave
// through a two-entry result queue; the last one of a tick carries last.
module midi_event_delay_queue_core import medq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  in_item_t cmd;
  logic cmd_valid, cmd_take;

  medq_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  medq_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .res(out_item), .empty(empty), .pop(pop)
  );

endmodule
